[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tssf check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tssf check failed");

`endif

[rtl/core/tssf_pkg.sv]
// shared widths, register codes and the trail entry layout
// no dependencies
package tssf_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int COORD_W        = 16;
  localparam int COLOR_W        = 8;
  localparam int CFG_LEN_W      = 6;
  localparam int IDX_W          = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;

  localparam logic [CFG_LEN_W-1:0] CHAIN_LENGTH_RST = CFG_LEN_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAIN_LENGTH,
    CFG_COLOR_RED,
    CFG_COLOR_GREEN,
    CFG_COLOR_BLUE,
    CFG_BASE_ALPHA
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic signed [COORD_W-1:0] near_z;
    logic signed [COORD_W-1:0] far_x;
    logic signed [COORD_W-1:0] far_y;
    logic signed [COORD_W-1:0] far_z;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic [COLOR_W-1:0]        alpha;
  } entry_t;

endpackage

[rtl/core/trail_strip_shift_fade.sv]
// ribbon trail store with linear alpha fade, emits the whole trail per new head
// depends on tssf_pkg and tssf_div
//
//  channel  signals                      direction  carries
//  in       in_valid / in_ready          to block   new head near/far vertex, fade_enable
//  out      out_valid / out_ready        from block one trail entry, head first, is_last
//  cfg      cfg_valid / cfg_ready        to block   cfg_index, cfg_data
//
// one item runs through these steps in order: take the head, run the serial
// divider that sets the fade step, then read each ring entry and write back the faded ones
// reset clears the state and config registers and the entry valid bits at once, no sweep
// a stalled output holds the sequencer on the current entry; a new head is
// taken while the tail entry still waits in the output register
module trail_strip_shift_fade
  import tssf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] near_x,
  input  logic signed [COORD_W-1:0] near_y,
  input  logic signed [COORD_W-1:0] near_z,
  input  logic signed [COORD_W-1:0] far_x,
  input  logic signed [COORD_W-1:0] far_y,
  input  logic signed [COORD_W-1:0] far_z,
  input  logic                      fade_enable,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          entry_index,
  output logic signed [COORD_W-1:0] out_near_x,
  output logic signed [COORD_W-1:0] out_near_y,
  output logic signed [COORD_W-1:0] out_near_z,
  output logic signed [COORD_W-1:0] out_far_x,
  output logic signed [COORD_W-1:0] out_far_y,
  output logic signed [COORD_W-1:0] out_far_z,
  output logic [COLOR_W-1:0]        out_red,
  output logic [COLOR_W-1:0]        out_green,
  output logic [COLOR_W-1:0]        out_blue,
  output logic [COLOR_W-1:0]        out_alpha,
  output logic                      is_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int PTR_W = $clog2(MAX_POINTS);
  localparam int LEN_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_POINTS - 1);

  typedef enum logic [1:0] {
    IDLE,
    DIV,
    RD,
    PROC
  } state_t;

  state_t state;

  // configuration registers
  logic [CFG_LEN_W-1:0] chain_length;
  logic [COLOR_W-1:0]   color_red;
  logic [COLOR_W-1:0]   color_green;
  logic [COLOR_W-1:0]   color_blue;
  logic [COLOR_W-1:0]   base_alpha;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length <= CHAIN_LENGTH_RST;
      color_red    <= '0;
      color_green  <= '0;
      color_blue   <= '0;
      base_alpha   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHAIN_LENGTH: chain_length <= cfg_data[CFG_LEN_W-1:0];
        CFG_COLOR_RED:    color_red    <= cfg_data[COLOR_W-1:0];
        CFG_COLOR_GREEN:  color_green  <= cfg_data[COLOR_W-1:0];
        CFG_COLOR_BLUE:   color_blue   <= cfg_data[COLOR_W-1:0];
        CFG_BASE_ALPHA:   base_alpha   <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped length, kept as n-1
  logic [CMP_W-1:0] len_wide;
  logic [PTR_W-1:0] len_last;

  assign len_wide = CMP_W'(chain_length);

  always_comb begin
    if (len_wide < CMP_W'(2)) begin
      len_last = PTR_W'(1);
    end else if (len_wide > CMP_W'(MAX_POINTS)) begin
      len_last = LAST_SLOT;
    end else begin
      len_last = PTR_W'(len_wide - CMP_W'(1));
    end
  end

  // sequencer registers
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   slot;
  logic [PTR_W-1:0]   idx;
  logic [PTR_W-1:0]   n_last;
  logic [COLOR_W-1:0] q_run;
  logic [PTR_W-1:0]   r_run;

  logic [PTR_W-1:0]   head_next;
  logic [PTR_W-1:0]   slot_next;
  logic [COLOR_W-1:0] q_next;
  logic [PTR_W-1:0]   r_next;
  logic [PTR_W:0]     r_sub;

  logic               in_fire;
  logic               out_free;
  logic               out_load;

  // divider for the fade step
  logic               div_done;
  logic [COLOR_W-1:0] div_quot;
  logic [PTR_W-1:0]   div_rem;

  tssf_div #(
    .DIV_W (PTR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire),
    .dividend (base_alpha),
    .divisor  (len_last),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // ring memory
  entry_t             mem [MAX_POINTS];
  entry_t             rd_word;
  logic               rd_vld;
  logic [MAX_POINTS-1:0] vld;
  logic               we;
  logic [PTR_W-1:0]   waddr;
  entry_t             wdata;
  entry_t             head_word;
  entry_t             cur;
  entry_t             upd;
  logic               fade;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[slot];
    end
  end

  assign in_ready  = (state == IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == PROC) && out_free;
  assign head_next = (head == '0) ? LAST_SLOT : head - PTR_W'(1);
  assign slot_next = (slot == LAST_SLOT) ? '0 : slot + PTR_W'(1);

  always_comb begin
    head_word.near_x = near_x;
    head_word.near_y = near_y;
    head_word.near_z = near_z;
    head_word.far_x  = far_x;
    head_word.far_y  = far_y;
    head_word.far_z  = far_z;
    head_word.red    = color_red;
    head_word.green  = color_green;
    head_word.blue   = color_blue;
    head_word.alpha  = fade_enable ? base_alpha : '0;
  end

  always_comb begin
    cur  = rd_vld ? rd_word : '0;
    fade = (idx != '0) && (cur.alpha != '0);
    upd  = cur;
    if (fade) begin
      upd.alpha = q_run;
    end
    we    = in_fire || ((state == PROC) && out_free && fade);
    waddr = in_fire ? head_next : slot;
    wdata = in_fire ? head_word : upd;
  end

  // running quotient and remainder of base_alpha*(n-1-i)/(n-1)
  always_comb begin
    r_sub = {1'b0, r_run} - {1'b0, div_rem};
    if (r_run < div_rem) begin
      r_next = PTR_W'(r_sub + {1'b0, n_last});
      q_next = q_run - div_quot - COLOR_W'(1);
    end else begin
      r_next = PTR_W'(r_sub);
      q_next = q_run - div_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      head      <= '0;
      slot      <= '0;
      idx       <= '0;
      n_last    <= PTR_W'(1);
      q_run     <= '0;
      r_run     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        IDLE: begin
          if (in_fire) begin
            head   <= head_next;
            slot   <= head_next;
            idx    <= '0;
            n_last <= len_last;
            state  <= DIV;
          end
        end
        DIV: begin
          if (div_done) begin
            q_run <= base_alpha;
            r_run <= '0;
            state <= RD;
          end
        end
        RD: begin
          state <= PROC;
        end
        PROC: begin
          if (out_free) begin
            entry_index <= IDX_W'(idx);
            out_near_x  <= upd.near_x;
            out_near_y  <= upd.near_y;
            out_near_z  <= upd.near_z;
            out_far_x   <= upd.far_x;
            out_far_y   <= upd.far_y;
            out_far_z   <= upd.far_z;
            out_red     <= upd.red;
            out_green   <= upd.green;
            out_blue    <= upd.blue;
            out_alpha   <= upd.alpha;
            is_last     <= (idx == n_last);
            if (idx == n_last) begin
              state <= IDLE;
            end else begin
              idx   <= idx + PTR_W'(1);
              slot  <= slot_next;
              q_run <= q_next;
              r_run <= r_next;
              state <= RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/tssf_div.sv]
// bit-serial restoring divider: alpha value by trail length minus one
// depends on tssf_pkg
module tssf_div
  import tssf_pkg::*;
#(
  parameter int DIV_W = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COLOR_W-1:0] dividend,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [COLOR_W-1:0] quot,
  output logic [DIV_W-1:0]   rem
);

  localparam int CNT_W = $clog2(COLOR_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [COLOR_W-1:0] dq;
  logic [DIV_W-1:0]   rem_r;
  logic [DIV_W-1:0]   dsr;
  logic [DIV_W:0]     part;
  logic               take;

  assign part = {rem_r, dq[COLOR_W-1]};
  assign take = part >= {1'b0, dsr};
  assign quot = dq;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(COLOR_W - 1);
        dq    <= dividend;
        rem_r <= '0;
        dsr   <= divisor;
      end else if (busy) begin
        rem_r <= take ? DIV_W'(part - {1'b0, dsr}) : DIV_W'(part);
        dq    <= {dq[COLOR_W-2:0], take};
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

endmodule

[rtl/core/tssf_checker.sv]
// port-level checks on the trail block, bound to trail_strip_shift_fade
// depends on tssf_pkg, assert_macros.svh and trail_strip_shift_fade
`include "assert_macros.svh"

module tssf_checker
  import tssf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] entry_index,
  input logic             is_last
);

  // stalled output entry holds
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(entry_index) && $stable(is_last))

  // an input transfer starts a busy run
  `ASSERT_NXT(a_busy_after_in, clk, rst, in_valid && in_ready, !in_ready)

  // no entry of the new run right after a head transfer
  `ASSERT_NXT(a_no_early_entry, clk, rst, in_valid && in_ready, !out_valid || is_last)

  // while idle only the tail entry can be pending
  `ASSERT_IMP(a_idle_tail, clk, rst, out_valid && in_ready, is_last)

endmodule

bind trail_strip_shift_fade tssf_checker u_tssf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .entry_index (entry_index),
  .is_last     (is_last)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// testbench for trail_strip_shift_fade: directed and random head transfers, a ring
// predictor of the faded trail and a field by field check of every entry transfer
// depends on tssf_pkg and the trail_strip_shift_fade rtl
module tb;
  import tssf_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_HEADS = 285;
  localparam int LONG_HOLD    = 600;
  localparam int SETTLE       = 100;

  typedef struct packed {
    logic signed [COORD_W-1:0] near_x, near_y, near_z, far_x, far_y, far_z;
    logic                      fade;
  } head_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    entry_t           ent;
    logic             tail;
  } trail_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] near_x = '0;
  logic signed [COORD_W-1:0] near_y = '0;
  logic signed [COORD_W-1:0] near_z = '0;
  logic signed [COORD_W-1:0] far_x = '0;
  logic signed [COORD_W-1:0] far_y = '0;
  logic signed [COORD_W-1:0] far_z = '0;
  logic                      fade_enable = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [IDX_W-1:0]          entry_index;
  logic signed [COORD_W-1:0] out_near_x, out_near_y, out_near_z;
  logic signed [COORD_W-1:0] out_far_x, out_far_y, out_far_z;
  logic [COLOR_W-1:0]        out_red, out_green, out_blue, out_alpha;
  logic                      is_last;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // predictor state
  entry_t               trail_ring [MAX_POINTS_DEF];
  logic [IDX_W-1:0]     ring_head;
  logic [CFG_LEN_W-1:0] len_reg;
  logic [COLOR_W-1:0]   red_reg, green_reg, blue_reg, alpha_reg;

  head_t      head_queue [$];
  trail_rec_t trail_expect [$];
  head_t      offered;
  trail_rec_t want_rec;
  int heads_queued = 0;
  int heads_accepted = 0;
  int error_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int cycle_count = 0;

  trail_strip_shift_fade DUT (.*);

  always #5 clk = ~clk;

  // shift the ring, place the new head, fade the older entries, queue the whole trail
  function automatic void predict_trail(input head_t h);
    int n;
    logic [IDX_W-1:0] s;
    trail_rec_t r;
    n = (len_reg < 2) ? 2 : (len_reg > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(len_reg);
    ring_head = ring_head - 1'b1;
    trail_ring[ring_head] = '{h.near_x, h.near_y, h.near_z, h.far_x, h.far_y, h.far_z,
                              red_reg, green_reg, blue_reg, h.fade ? alpha_reg : '0};
    for (int i = 1; i < n; i++) begin
      s = ring_head + IDX_W'(i);
      if (trail_ring[s].alpha != '0)
        trail_ring[s].alpha = COLOR_W'(int'(alpha_reg) * (n - 1 - i) / (n - 1));
    end
    for (int i = 0; i < n; i++) begin
      s = ring_head + IDX_W'(i);
      r.index = IDX_W'(i);
      r.ent = trail_ring[s];
      r.tail = (i == n - 1);
      trail_expect.push_back(r);
    end
  endfunction

  function automatic void queue_head(input head_t h);
    head_queue.push_back(h);
    heads_queued++;
  endfunction

  function automatic void queue_fill(input logic [COORD_W-1:0] v, input logic f);
    queue_head('{v, v, v, v, v, v, f});
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // mostly short trails, sometimes the full length and out of range values
  function automatic logic [CFG_DATA_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom_range(0, 1));
      1: return 8'd32;
      2: return CFG_DATA_W'($urandom_range(33, 63));
      3: return CFG_DATA_W'($urandom_range(64, 255));
      4: return 8'd2;
      default: return CFG_DATA_W'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_CHAIN_LENGTH: len_reg = val[CFG_LEN_W-1:0];
      CFG_COLOR_RED:    red_reg = val;
      CFG_COLOR_GREEN:  green_reg = val;
      CFG_COLOR_BLUE:   blue_reg = val;
      CFG_BASE_ALPHA:   alpha_reg = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (heads_accepted != heads_queued || trail_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // head transfers
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_trail(offered);
        heads_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (head_queue.size() != 0) begin
          offered = head_queue.pop_front();
          near_x <= offered.near_x;
          near_y <= offered.near_y;
          near_z <= offered.near_z;
          far_x <= offered.far_x;
          far_y <= offered.far_y;
          far_z <= offered.far_z;
          fade_enable <= offered.fade;
          in_valid <= 1'b1;
          if ($urandom_range(0, 99) < send_gap_pct) gap_left = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // entry transfers
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (trail_expect.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected entry transfer, index %0d", entry_index);
        end else begin
          want_rec = trail_expect.pop_front();
          compare_field("entry_index", want_rec.index, entry_index);
          compare_field("out_near_x", want_rec.ent.near_x, out_near_x);
          compare_field("out_near_y", want_rec.ent.near_y, out_near_y);
          compare_field("out_near_z", want_rec.ent.near_z, out_near_z);
          compare_field("out_far_x", want_rec.ent.far_x, out_far_x);
          compare_field("out_far_y", want_rec.ent.far_y, out_far_y);
          compare_field("out_far_z", want_rec.ent.far_z, out_far_z);
          compare_field("out_red", want_rec.ent.red, out_red);
          compare_field("out_green", want_rec.ent.green, out_green);
          compare_field("out_blue", want_rec.ent.blue, out_blue);
          compare_field("out_alpha", want_rec.ent.alpha, out_alpha);
          compare_field("is_last", want_rec.tail, is_last);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        stall_left = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int phase_no;
    int batch;
    int sent_random;
    foreach (trail_ring[k]) trail_ring[k] = '0;
    ring_head = '0;
    len_reg = CHAIN_LENGTH_RST;
    red_reg = '0;
    green_reg = '0;
    blue_reg = '0;
    alpha_reg = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: two entries, black, no alpha
    queue_fill(16'h8000, 1'b1);
    queue_fill(16'h7fff, 1'b0);
    wait_idle();

    write_reg(CFG_CHAIN_LENGTH, 8'd32);
    write_reg(CFG_COLOR_RED, 8'hff);
    write_reg(CFG_COLOR_GREEN, 8'h00);
    write_reg(CFG_COLOR_BLUE, 8'haa);
    write_reg(CFG_BASE_ALPHA, 8'hff);
    // unknown indexes must be ignored
    for (int k = int'(CFG_BASE_ALPHA) + 1; k < 2 ** CFG_IDX_W; k++)
      write_reg(CFG_IDX_W'(k), k[0] ? 8'h5a : 8'ha5);
    queue_fill('0, 1'b1);
    queue_fill('1, 1'b1);
    queue_fill(16'h8000, 1'b0);
    queue_fill(16'h7fff, 1'b1);
    queue_head('{16'h7fff, 16'h8000, 16'h0001, 16'hfffe, 16'h5555, 16'haaaa, 1'b1});
    wait_idle();

    // zero base alpha fades every lit entry to zero
    write_reg(CFG_BASE_ALPHA, 8'd0);
    queue_fill(16'h1234, 1'b1);
    wait_idle();

    // lengths below and above range, old ring slots coming into view
    write_reg(CFG_BASE_ALPHA, 8'd200);
    write_reg(CFG_CHAIN_LENGTH, 8'd0);
    queue_fill(16'h0f0f, 1'b1);
    queue_fill(16'hf0f0, 1'b1);
    wait_idle();
    write_reg(CFG_CHAIN_LENGTH, 8'd1);
    queue_fill(16'h00ff, 1'b1);
    wait_idle();
    write_reg(CFG_CHAIN_LENGTH, 8'd63);
    queue_fill(16'hff00, 1'b1);
    queue_fill(16'h4321, 1'b0);
    wait_idle();
    write_reg(CFG_CHAIN_LENGTH, 8'd33);
    queue_fill(16'h2468, 1'b1);
    wait_idle();
    write_reg(CFG_CHAIN_LENGTH, 8'hc5);
    queue_fill(16'h1357, 1'b1);
    queue_fill(16'h8001, 1'b1);
    wait_idle();

    phase_no = 0;
    sent_random = 0;
    while (sent_random < RANDOM_HEADS) begin
      if ($urandom_range(0, 2) != 0) write_reg(CFG_CHAIN_LENGTH, pick_length());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_COLOR_RED, pick_color());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_COLOR_GREEN, pick_color());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_COLOR_BLUE, pick_color());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_BASE_ALPHA, pick_color());
      if (sent_random >= RANDOM_HEADS - 50) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: send_gap_pct = 0;
          1: send_gap_pct = 10;
          default: send_gap_pct = 40;
        endcase
        case ($urandom_range(0, 3))
          0: recv_stall_pct = 0;
          1: recv_stall_pct = 5;
          default: recv_stall_pct = 20;
        endcase
      end
      batch = (phase_no == 2) ? 30 : $urandom_range(10, 30);
      for (int k = 0; k < batch; k++)
        queue_head('{pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(),
                     logic'($urandom_range(0, 3) != 0)});
      // receiver holds off while heads keep coming
      if (phase_no == 2) hold_requests <= hold_requests + 1;
      sent_random += batch;
      phase_no++;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
